FILE: hw/rtl/rdu_pkg.sv
// ----------------------------------------------------------------------------
// rdu_pkg: shared types for the refraction direction unit
// Direction components and refractive index fields as seen on the ports.
// ----------------------------------------------------------------------------
package rdu_pkg;

    localparam int VEC_W = 16;
    localparam int IDX_W = 14;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic        [IDX_W-1:0] t_idx;

endpackage

FILE: hw/rtl/refraction_direction_unit.sv
// ----------------------------------------------------------------------------
// refraction_direction_unit: Snell refraction of a unit ray direction
// Fully pipelined; one ray may enter on every clock cycle.
// ----------------------------------------------------------------------------
// A ray is taken on every cycle that start is high; busy is always low. Each
// ray gives one beat on o_valid; its path runs through two bit-per-stage
// square-root chains and two bit-per-stage dividers in series. Results
// cannot be held off: sample them when o_valid is high.
// o_refracted low means total internal reflection, with a zero direction.
// ----------------------------------------------------------------------------
module refraction_direction_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rdu_pkg::t_vec i_inc_x,
    input  rdu_pkg::t_vec i_inc_y,
    input  rdu_pkg::t_vec i_inc_z,
    input  rdu_pkg::t_vec i_nrm_x,
    input  rdu_pkg::t_vec i_nrm_y,
    input  rdu_pkg::t_vec i_nrm_z,
    input  rdu_pkg::t_idx i_index_from,
    input  rdu_pkg::t_idx i_index_to,
    output rdu_pkg::t_vec o_out_x,
    output rdu_pkg::t_vec o_out_y,
    output rdu_pkg::t_vec o_out_z,
    output logic          o_refracted,
    output logic          o_valid
);

    import rdu_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int DOT_W = 2 * VEC_W + 2;
    localparam int CIW   = DOT_W - F;
    localparam int NCIW  = VEC_W + CIW;
    localparam int WT    = (49 - 2 * F > 18) ? 49 - 2 * F : 18;
    localparam int LW    = 2 * WT;
    localparam int AW    = 2 * F + 1;
    localparam int SQW   = (AW > LW) ? AW : LW;
    localparam int SN    = (SQW + 1) / 2;
    localparam int QW    = F + 1;
    localparam int PW    = QW + IDX_W;
    localparam int TNW   = WT + QW;
    localparam int NCW   = VEC_W + 2;
    localparam int TW    = QW + 1;
    localparam int VVW   = ((TW > NCW) ? TW : NCW) + 1;
    localparam int LIMV  = (F >= 15) ? 32767 : (1 << F);
    localparam int S1SW  = 3 * WT + 3 * VEC_W + 2 * IDX_W;
    localparam int D1SW  = 3 * WT + 3 * VEC_W + LW + 2;
    localparam int SASW  = QW + 3 * WT + 3 * VEC_W;

    localparam logic signed [DOT_W-1:0] ONE_DOT = DOT_W'(1) <<< F;
    localparam logic        [AW-1:0]    ONE2F   = AW'(1) << (2 * F);
    localparam logic signed [VVW-1:0]   LIM     = VVW'(LIMV);

    t_vec d_in [3];
    t_vec nv_in[3];

    // stage registers
    logic                     r1_vld, r2_vld, r3_vld, r4_vld;
    logic                     r5_vld, r6_vld, r7_vld, r8_vld, r9_vld;
    logic signed [2*VEC_W-1:0] r1_pr[3];
    t_vec                     r1_d[3], r1_n[3], r2_d[3], r2_n[3];
    t_vec                     r3_d[3], r3_n[3], r4_n[3];
    t_idx                     r1_fi, r1_ti, r2_fi, r2_ti, r3_fi, r3_ti, r4_fi, r4_ti;
    logic signed [CIW-1:0]    r2_cos;
    logic                     r3_big;
    logic        [2*F-1:0]    r3_cos2;
    logic signed [NCIW-1:0]   r3_nc[3];
    logic        [AW-1:0]     r4_arg;
    logic signed [WT-1:0]     r4_t[3];

    logic                     s1_vld;
    logic        [QW-1:0]     s1_root;
    logic        [S1SW-1:0]   s1_sb;
    logic signed [WT-1:0]     s1_t[3];
    t_vec                     s1_n[3];
    t_idx                     s1_fi, s1_ti;

    logic        [PW-1:0]     r5_psi, r6_psi;
    logic        [LW-1:0]     r5_tsq[3];
    logic signed [WT-1:0]     r5_t[3], r6_t[3];
    t_vec                     r5_n[3], r6_n[3];
    t_idx                     r5_ti, r6_ti;
    logic                     r6_tir, r6_tz;
    logic        [LW-1:0]     r6_len2;

    logic                     d1_vld;
    logic        [QW-1:0]     d1_q;
    logic        [D1SW-1:0]   d1_sb;
    logic signed [WT-1:0]     d1_t[3];
    t_vec                     d1_n[3];
    logic        [LW-1:0]     d1_len2;
    logic                     d1_tir, d1_tz;

    logic        [QW-1:0]     n_sint;
    logic        [QW-1:0]     r7_sint, r8_sint;
    logic        [2*QW-1:0]   r7_s2;
    logic        [2*QW-1:0]   n_carg;
    logic signed [WT-1:0]     r7_t[3], r8_t[3];
    t_vec                     r7_n[3], r8_n[3];
    logic        [LW-1:0]     r7_len2, r8_len2;
    logic                     r7_tir, r8_tir;
    logic        [AW-1:0]     r8_carg;

    logic                     sa_vld;
    logic        [SN-1:0]     sa_root, sb_root;
    logic        [SASW-1:0]   sa_sb;
    logic                     sb_tir;
    logic        [QW-1:0]     sa_sint;
    logic signed [WT-1:0]     sa_t[3];
    t_vec                     sa_n[3];
    logic        [QW-1:0]     n_cost;
    logic        [WT-1:0]     n_len;
    logic        [WT-1:0]     n_tabs[3];
    logic signed [VEC_W+QW:0] n_ncp[3];

    logic        [TNW-1:0]    r9_num[3];
    logic                     r9_neg[3];
    logic signed [NCW-1:0]    r9_nct[3];
    logic        [WT-1:0]     r9_len;
    logic                     r9_lz, r9_tir;

    logic                     dv_vld;
    logic        [QW-1:0]     dv_q[3];
    logic                     dv_rnz[3];
    logic                     dv_neg[3];
    logic signed [NCW-1:0]    dv_nct[3];
    logic                     dv_tir, dv_lz;

    logic signed [DOT_W-1:0]  n_dot, n_sh, n_cosx, n_mag;
    logic        [F-1:0]      n_magf;
    logic                     n_big;
    logic signed [NCIW-1:0]   n_tsum[3];
    logic signed [TW-1:0]     n_term[3];
    logic signed [VVW-1:0]    n_v[3];
    t_vec                     n_o[3];

    t_vec                     r_out[3];
    logic                     r_refr, r_vld;

    // the pipeline never stalls
    assign busy = 1'b0;

    always_comb begin
        d_in[0]  = i_inc_x;
        d_in[1]  = i_inc_y;
        d_in[2]  = i_inc_z;
        nv_in[0] = i_nrm_x;
        nv_in[1] = i_nrm_y;
        nv_in[2] = i_nrm_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r1_vld <= start & ~busy;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= s1_vld;
            r6_vld <= r5_vld;
            r7_vld <= d1_vld;
            r8_vld <= r7_vld;
            r9_vld <= sa_vld;
            r_vld  <= dv_vld;
        end
    end

    // cosine of incidence, clamp test and tangent vector
    always_comb begin
        n_dot  = DOT_W'(r1_pr[0]) + DOT_W'(r1_pr[1]) + DOT_W'(r1_pr[2]);
        n_sh   = (-n_dot) >>> F;
        n_cosx = DOT_W'(r2_cos);
        n_big  = (n_cosx >= ONE_DOT) || (n_cosx <= -ONE_DOT);
        n_mag  = (n_cosx < 0) ? -n_cosx : n_cosx;
        n_magf = n_mag[F-1:0];
        for (int a = 0; a < 3; a++) begin
            n_tsum[a] = NCIW'(r3_d[a]) + (r3_nc[a] >>> F);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r1_pr[a] <= d_in[a] * nv_in[a];
            r1_d[a]  <= d_in[a];
            r1_n[a]  <= nv_in[a];
            r2_d[a]  <= r1_d[a];
            r2_n[a]  <= r1_n[a];
            r3_d[a]  <= r2_d[a];
            r3_n[a]  <= r2_n[a];
            r3_nc[a] <= r2_n[a] * r2_cos;
            r4_n[a]  <= r3_n[a];
            r4_t[a]  <= WT'(n_tsum[a]);
        end
        r1_fi   <= i_index_from;
        r1_ti   <= i_index_to;
        r2_fi   <= r1_fi;
        r2_ti   <= r1_ti;
        r2_cos  <= n_sh[CIW-1:0];
        r3_fi   <= r2_fi;
        r3_ti   <= r2_ti;
        r3_big  <= n_big;
        r3_cos2 <= n_magf * n_magf;
        r4_fi   <= r3_fi;
        r4_ti   <= r3_ti;
        r4_arg  <= r3_big ? '0 : ONE2F - {1'b0, r3_cos2};
    end

    // sine of incidence
    rdu_sqrt #(
        .RW (AW),
        .SW (S1SW)
    ) u_sqrt_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r4_vld),
        .i_rad   (r4_arg),
        .i_sb    ({r4_t[0], r4_t[1], r4_t[2], r4_n[0], r4_n[1], r4_n[2], r4_fi, r4_ti}),
        .o_vld   (s1_vld),
        .o_root  (s1_root),
        .o_sb    (s1_sb)
    );

    assign {s1_t[0], s1_t[1], s1_t[2], s1_n[0], s1_n[1], s1_n[2], s1_fi, s1_ti} = s1_sb;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r5_tsq[a] <= s1_t[a] * s1_t[a];
            r5_t[a]   <= s1_t[a];
            r5_n[a]   <= s1_n[a];
            r6_t[a]   <= r5_t[a];
            r6_n[a]   <= r5_n[a];
        end
        r5_psi  <= PW'(s1_root) * PW'(s1_fi);
        r5_ti   <= s1_ti;
        r6_psi  <= r5_psi;
        r6_ti   <= r5_ti;
        r6_tz   <= (r5_ti == '0);
        r6_tir  <= r5_psi > (PW'(r5_ti) << F);
        r6_len2 <= r5_tsq[0] + r5_tsq[1] + r5_tsq[2];
    end

    // transmitted sine: sinI * index_from / index_to
    rdu_div #(
        .NW (PW),
        .DW (IDX_W),
        .QW (QW),
        .SW (D1SW)
    ) u_div_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r6_vld),
        .i_num   (r6_psi),
        .i_den   (r6_ti),
        .i_sb    ({r6_t[0], r6_t[1], r6_t[2], r6_n[0], r6_n[1], r6_n[2],
                   r6_len2, r6_tir, r6_tz}),
        .o_vld   (d1_vld),
        .o_quo   (d1_q),
        .o_rnz   (),
        .o_sb    (d1_sb)
    );

    assign {d1_t[0], d1_t[1], d1_t[2], d1_n[0], d1_n[1], d1_n[2],
            d1_len2, d1_tir, d1_tz} = d1_sb;

    always_comb begin
        // a zero exit index leaves the ray along the normal
        n_sint = d1_tz ? '0 : d1_q;
        n_carg = (2 * QW)'(ONE2F) - r7_s2;
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r7_t[a] <= d1_t[a];
            r7_n[a] <= d1_n[a];
            r8_t[a] <= r7_t[a];
            r8_n[a] <= r7_n[a];
        end
        r7_sint <= n_sint;
        r7_s2   <= n_sint * n_sint;
        r7_len2 <= d1_len2;
        r7_tir  <= d1_tir;
        r8_sint <= r7_sint;
        r8_carg <= AW'(n_carg);
        r8_len2 <= r7_len2;
        r8_tir  <= r7_tir;
    end

    // transmitted cosine and tangent length, side by side
    rdu_sqrt #(
        .RW (SQW),
        .SW (SASW)
    ) u_sqrt_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r8_vld),
        .i_rad   (SQW'(r8_carg)),
        .i_sb    ({r8_sint, r8_t[0], r8_t[1], r8_t[2], r8_n[0], r8_n[1], r8_n[2]}),
        .o_vld   (sa_vld),
        .o_root  (sa_root),
        .o_sb    (sa_sb)
    );

    rdu_sqrt #(
        .RW (SQW),
        .SW (1)
    ) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r8_vld),
        .i_rad   (SQW'(r8_len2)),
        .i_sb    (r8_tir),
        .o_vld   (),
        .o_root  (sb_root),
        .o_sb    (sb_tir)
    );

    assign {sa_sint, sa_t[0], sa_t[1], sa_t[2], sa_n[0], sa_n[1], sa_n[2]} = sa_sb;

    always_comb begin
        n_cost = QW'(sa_root);
        n_len  = WT'(sb_root);
        for (int a = 0; a < 3; a++) begin
            n_tabs[a] = (sa_t[a] < 0) ? $unsigned(-sa_t[a]) : $unsigned(sa_t[a]);
            n_ncp[a]  = sa_n[a] * $signed({1'b0, n_cost});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r9_num[a] <= TNW'(n_tabs[a]) * TNW'(sa_sint);
            r9_neg[a] <= sa_t[a][WT-1];
            r9_nct[a] <= NCW'(n_ncp[a] >>> F);
        end
        r9_len <= n_len;
        r9_lz  <= (n_len == '0);
        r9_tir <= sb_tir;
    end

    // tangent term per axis: t * sinT / |t|
    for (genvar a = 0; a < 3; a++) begin : g_axis
        if (a == 0) begin : g_lead
            rdu_div #(
                .NW (TNW),
                .DW (WT),
                .QW (QW),
                .SW (NCW + 3)
            ) u_div_tan (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (r9_vld),
                .i_num   (r9_num[a]),
                .i_den   (r9_len),
                .i_sb    ({r9_tir, r9_lz, r9_neg[a], r9_nct[a]}),
                .o_vld   (dv_vld),
                .o_quo   (dv_q[a]),
                .o_rnz   (dv_rnz[a]),
                .o_sb    ({dv_tir, dv_lz, dv_neg[a], dv_nct[a]})
            );
        end else begin : g_other
            rdu_div #(
                .NW (TNW),
                .DW (WT),
                .QW (QW),
                .SW (NCW + 1)
            ) u_div_tan (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (r9_vld),
                .i_num   (r9_num[a]),
                .i_den   (r9_len),
                .i_sb    ({r9_neg[a], r9_nct[a]}),
                .o_vld   (),
                .o_quo   (dv_q[a]),
                .o_rnz   (dv_rnz[a]),
                .o_sb    ({dv_neg[a], dv_nct[a]})
            );
        end
    end

    // floor the signed quotient, drop the normal part, saturate
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (dv_lz) begin
                n_term[a] = '0;
            end else if (dv_neg[a]) begin
                n_term[a] = -$signed({1'b0, dv_q[a]}) - TW'(dv_rnz[a]);
            end else begin
                n_term[a] = $signed({1'b0, dv_q[a]});
            end
            n_v[a] = VVW'(n_term[a]) - VVW'(dv_nct[a]);
            if (n_v[a] > LIM) begin
                n_v[a] = LIM;
            end else if (n_v[a] < -LIM) begin
                n_v[a] = -LIM;
            end
            n_o[a] = dv_tir ? '0 : n_v[a][VEC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_out[a] <= n_o[a];
        end
        r_refr <= ~dv_tir;
    end

    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_refracted = r_refr;
    assign o_valid     = r_vld;

endmodule

FILE: hw/rtl/rdu_sqrt.sv
// ----------------------------------------------------------------------------
// rdu_sqrt: pipelined floor square root
// One root bit per register stage, restoring digit recurrence. A sideband
// word and a valid bit travel alongside each radicand.
// ----------------------------------------------------------------------------
module rdu_sqrt #(
    parameter int RW = 30,
    parameter int SW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [RW-1:0]           i_rad,
    input  logic [SW-1:0]           i_sb,
    output logic                    o_vld,
    output logic [(RW+1)/2-1:0]     o_root,
    output logic [SW-1:0]           o_sb
);

    localparam int N  = (RW + 1) / 2;
    localparam int PW = 2 * N;

    logic [PW-1:0]  r_rad  [N];
    logic [N+1:0]   r_rem  [N];
    logic [N-1:0]   r_root [N];
    logic [SW-1:0]  r_sb   [N];
    logic           r_vld  [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [PW-1:0] rad_in;
        logic [N+1:0]  rem_in;
        logic [N-1:0]  root_in;
        logic [SW-1:0] sb_in;
        logic          vld_in;
        logic [N+1:0]  n_sh;
        logic [N+1:0]  n_trial;
        logic [N+1:0]  n_rem;
        logic [N-1:0]  n_root;
        logic          n_ge;

        if (s == 0) begin : g_first
            assign rad_in  = PW'(i_rad);
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = i_sb;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rad_in  = r_rad[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign sb_in   = r_sb[s-1];
            assign vld_in  = r_vld[s-1];
        end

        // bring down the next pair of radicand bits and try a one
        always_comb begin
            n_sh    = {rem_in[N-1:0], rad_in[2*(N-1-s)+1 -: 2]};
            n_trial = {root_in, 2'b01};
            n_ge    = n_sh >= n_trial;
            n_rem   = n_ge ? n_sh - n_trial : n_sh;
            n_root  = {root_in[N-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[s]  <= rad_in;
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_sb[s]   <= sb_in;
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_sb   = r_sb[N-1];

endmodule

FILE: hw/rtl/rdu_div.sv
// ----------------------------------------------------------------------------
// rdu_div: pipelined unsigned restoring divider
// One quotient bit per register stage. The numerator must stay below
// divisor * 2^QW. Gives the quotient and whether a remainder is left.
// ----------------------------------------------------------------------------
module rdu_div #(
    parameter int NW = 29,
    parameter int DW = 14,
    parameter int QW = 15,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_sb,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic          o_rnz,
    output logic [SW-1:0] o_sb
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic [SW-1:0] r_sb  [QW];
    logic          r_vld [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] sb_in;
        logic          vld_in;
        logic [CW-1:0] n_rx;
        logic [CW-1:0] n_dsh;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;
        logic          n_ge;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign sb_in  = i_sb;
            assign vld_in = i_vld;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
            assign sb_in  = r_sb[s-1];
            assign vld_in = r_vld[s-1];
        end

        // subtract the divisor aligned to this quotient bit if it fits
        always_comb begin
            n_rx  = CW'(rem_in);
            n_dsh = CW'(den_in) << (QW - 1 - s);
            n_ge  = n_rx >= n_dsh;
            n_rem = n_ge ? NW'(n_rx - n_dsh) : rem_in;
            n_quo = {quo_in[QW-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_den[s] <= den_in;
            r_quo[s] <= n_quo;
            r_sb[s]  <= sb_in;
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_quo[QW-1];
    assign o_rnz = |r_rem[QW-1];
    assign o_sb  = r_sb[QW-1];

endmodule

FILE: bench/tb_refraction_direction_unit.sv
// ----------------------------------------------------------------------------
// tb_refraction_direction_unit: self-checking bench for Snell refraction
// Drives directed and random rays, predicts each transmitted direction in
// integer arithmetic and checks every o_valid beat in order.
// ----------------------------------------------------------------------------
module tb_refraction_direction_unit;
    import rdu_pkg::*;

    localparam int FB       = 14;
    localparam int LATENCY  = 76;
    localparam int N_RANDOM = 1430;

    typedef struct packed {
        t_vec ix, iy, iz, nx, ny, nz;
        t_idx nfrom, nto;
    } t_ray;

    typedef struct packed {
        t_vec ox, oy, oz;
        logic refr;
    } t_dir;

    typedef struct {
        t_ray ray;
        logic known;
        t_dir dir;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_vec i_inc_x, i_inc_y, i_inc_z, i_nrm_x, i_nrm_y, i_nrm_z;
    t_idx i_index_from, i_index_to;
    t_vec o_out_x, o_out_y, o_out_z;
    logic o_refracted;
    logic o_valid;

    t_dir pending_dirs[$];
    int   errors;
    t_row rows[$];
    t_dir cur_expect;

    refraction_direction_unit #(.FRAC_BITS(FB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_inc_x(i_inc_x), .i_inc_y(i_inc_y), .i_inc_z(i_inc_z),
        .i_nrm_x(i_nrm_x), .i_nrm_y(i_nrm_y), .i_nrm_z(i_nrm_z),
        .i_index_from(i_index_from), .i_index_to(i_index_to),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_refracted(o_refracted), .o_valid(o_valid)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint fl_shr(longint v);
        return v >>> FB;
    endfunction

    function automatic longint fl_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && ((a < 0) != (d < 0))) q--;
        return q;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic t_dir refract(t_ray r);
        longint d[3], nv[3], t[3], o[3];
        longint one, lim, dot, cos_i, sin_i, sin_t, cos_t, len, term;
        longint unsigned full, sq, len2, fi, ti;
        t_dir res;
        one  = 64'sd1 << FB;
        lim  = one < 32767 ? one : 32767;
        full = 64'd1 << (2 * FB);
        fi   = r.nfrom;
        ti   = r.nto;
        d[0] = r.ix; d[1] = r.iy; d[2] = r.iz;
        nv[0] = r.nx; nv[1] = r.ny; nv[2] = r.nz;
        dot   = d[0] * nv[0] + d[1] * nv[1] + d[2] * nv[2];
        cos_i = fl_shr(-dot);
        sq    = cos_i * cos_i;
        sin_i = isqrt(sq >= full ? 0 : full - sq);
        res   = '0;
        // total internal reflection: zero direction, flag low
        if (longint'(sin_i) * fi > (ti << FB)) return res;
        sin_t = ti != 0 ? longint'((longint'(sin_i) * fi) / ti) : 0;
        sq    = sin_t * sin_t;
        cos_t = isqrt(sq >= full ? 0 : full - sq);
        len2  = 0;
        for (int i = 0; i < 3; i++) begin
            t[i] = d[i] + fl_shr(nv[i] * cos_i);
            len2 += t[i] * t[i];
        end
        len = isqrt(len2);
        for (int i = 0; i < 3; i++) begin
            term = len != 0 ? fl_div(t[i] * sin_t, len) : 0;
            o[i] = term - fl_shr(nv[i] * cos_t);
            if (o[i] > lim) o[i] = lim;
            if (o[i] < -lim) o[i] = -lim;
        end
        res.ox = t_vec'(o[0]);
        res.oy = t_vec'(o[1]);
        res.oz = t_vec'(o[2]);
        res.refr = 1'b1;
        return res;
    endfunction

    function automatic t_vec rnd_comp();
        return t_vec'($urandom_range(32768) - 16384);
    endfunction

    // mostly unit vectors with small error; some raw full-range noise
    function automatic t_ray rnd_ray();
        t_ray r;
        real a, b, c, m;
        r.nfrom = t_idx'($urandom_range(16383, 4096));
        r.nto   = t_idx'($urandom_range(16383, 4096));
        if ($urandom_range(9) == 0) begin
            r.ix = t_vec'($urandom); r.iy = t_vec'($urandom); r.iz = t_vec'($urandom);
            r.nx = t_vec'($urandom); r.ny = t_vec'($urandom); r.nz = t_vec'($urandom);
            r.nfrom = t_idx'($urandom);
            r.nto   = t_idx'($urandom);
            return r;
        end
        a = real'(rnd_comp()); b = real'(rnd_comp()); c = real'(rnd_comp());
        m = $sqrt(a * a + b * b + c * c) + 1.0;
        r.nx = t_vec'(int'(a / m * 16384.0));
        r.ny = t_vec'(int'(b / m * 16384.0));
        r.nz = t_vec'(int'(c / m * 16384.0));
        a = real'(rnd_comp()); b = real'(rnd_comp()); c = real'(rnd_comp());
        m = $sqrt(a * a + b * b + c * c) + 1.0;
        r.ix = t_vec'(int'(a / m * 16384.0));
        r.iy = t_vec'(int'(b / m * 16384.0));
        r.iz = t_vec'(int'(c / m * 16384.0));
        return r;
    endfunction

    task automatic add_row(t_ray r, logic known, t_dir d);
        t_row w;
        w.ray = r; w.known = known; w.dir = d;
        rows.insert(rows.size(), w);
    endtask

    task automatic send_ray(t_ray r, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_inc_x      <= r.ix; i_inc_y <= r.iy; i_inc_z <= r.iz;
        i_nrm_x      <= r.nx; i_nrm_y <= r.ny; i_nrm_z <= r.nz;
        i_index_from <= r.nfrom;
        i_index_to   <= r.nto;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_dir exp_dir;
        if (i_rst_n && o_valid) begin
            if (pending_dirs.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                exp_dir = pending_dirs.pop_front();
                if (o_out_x !== exp_dir.ox) begin
                    $error("out_x expected %0d got %0d", exp_dir.ox, o_out_x);
                    errors++;
                end
                if (o_out_y !== exp_dir.oy) begin
                    $error("out_y expected %0d got %0d", exp_dir.oy, o_out_y);
                    errors++;
                end
                if (o_out_z !== exp_dir.oz) begin
                    $error("out_z expected %0d got %0d", exp_dir.oz, o_out_z);
                    errors++;
                end
                if (o_refracted !== exp_dir.refr) begin
                    $error("refracted expected %0d got %0d", exp_dir.refr, o_refracted);
                    errors++;
                end
            end
        end
    end

    // record the expectation at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            pending_dirs.insert(pending_dirs.size(), cur_expect);
    end

    always_comb cur_expect = refract({i_inc_x, i_inc_y, i_inc_z, i_nrm_x, i_nrm_y,
                                      i_nrm_z, i_index_from, i_index_to});

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_ray r;
        t_dir z, down;
        int phase_idle;
        errors       = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_inc_x      = '0; i_inc_y = '0; i_inc_z = '0;
        i_nrm_x      = '0; i_nrm_y = '0; i_nrm_z = '0;
        i_index_from = t_idx'(4096);
        i_index_to   = t_idx'(4096);
        z            = '0;
        down         = '0;
        down.oz      = t_vec'(-16384);
        down.refr    = 1'b1;

        // head-on ray along -z, equal indices: passes straight through
        add_row('{16'sh0, 16'sh0, -16'sd16384, 16'sh0, 16'sh0, 16'sd16384,
                  14'd4096, 14'd4096}, 1'b1, down);
        // grazing ray into a much thinner medium: total internal reflection
        add_row('{16'sd16384, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sd16384,
                  14'd16383, 14'd4096}, 1'b1, z);
        // zero index_to with nonzero sine: total internal reflection
        add_row('{16'sd16384, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sd16384,
                  14'd4096, 14'd0}, 1'b1, z);
        // zero index_to, head-on: passes along -N
        add_row('{16'sh0, 16'sh0, -16'sd16384, 16'sh0, 16'sh0, 16'sd16384,
                  14'd4096, 14'd0}, 1'b1, down);
        // all-zero vectors: zero tangent, sine clamps
        add_row('{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0,
                  14'd4096, 14'd4096}, 1'b0, z);
        add_row('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                  14'h3fff, 14'h3fff}, 1'b0, z);
        add_row('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  14'h0, 14'h3fff}, 1'b0, z);
        add_row('{16'shffff, 16'sh0001, 16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb,
                  14'h2aaa, 14'h1555}, 1'b0, z);
        add_row('{16'sd11585, 16'sh0, -16'sd11585, 16'sh0, 16'sh0, 16'sd16384,
                  14'd4096, 14'd6144}, 1'b0, z);
        add_row('{16'sd11585, 16'sh0, -16'sd11585, 16'sh0, 16'sh0, 16'sd16384,
                  14'd6144, 14'd4096}, 1'b0, z);
        add_row('{16'sh0, 16'sd16384, 16'sh0, 16'sh0, -16'sd16384, 16'sh0,
                  14'd5000, 14'd7000}, 1'b0, z);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].known && refract(rows[k].ray) !== rows[k].dir) begin
                $error("directed row %0d: table disagrees with prediction", k);
                errors++;
            end
            send_ray(rows[k].ray, 0);
        end
        start <= 1'b0;
        // hold until every beat has come back
        while (pending_dirs.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            phase_idle = n < N_RANDOM / 3 ? 7 : (n < 2 * N_RANDOM / 3 ? 78 : 0);
            r = rnd_ray();
            send_ray(r, phase_idle);
        end
        start <= 1'b0;

        while (pending_dirs.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
